// ----- rtl/tgi_pkg.sv -----
// Shared types and constants for the trilinear grid interpolator.
package tgi_pkg;

    typedef enum logic [2:0] {
        CMD_LOAD_X = 3'd0,
        CMD_LOAD_Y = 3'd1,
        CMD_LOAD_Z = 3'd2,
        CMD_LOAD_G = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        REG_X_POINTS = 2'd0,
        REG_Y_POINTS = 2'd1,
        REG_Z_POINTS = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_READ,
        ST_BLEND,
        ST_OUT
    } t_state;

    localparam int DIV_STEPS    = 16;
    localparam int CORNERS      = 8;
    localparam int BLEND_CYCLES = 14;
    localparam int IN_W         = 144;
    localparam int OUT_W        = 32;
    localparam int CNT_REG_W    = 5;

    typedef struct packed {
        logic       start;
        logic       scan_vld;
        logic       div_init;
        logic       div_step;
        logic       rd_vld;
        logic [2:0] rd_k;
        logic       bl_vld;
        logic       bl_phase;
        logic [2:0] bl_step;
        logic       out_load;
    } t_ctl;

endpackage

// ----- rtl/tgi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/tgi_axis.sv -----
// One axis: point table, neighbor scan and fraction divider.
module tgi_axis #(
    parameter int MAX_POINTS = 16,
    parameter int SCAN_W = 4,
    localparam int IW = $clog2(MAX_POINTS)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [11:0]                 i_waddr,
    input  logic signed [31:0]          i_wdata,
    input  logic [tgi_pkg::CNT_REG_W-1:0] i_points,
    input  logic signed [31:0]          i_coord,
    input  tgi_pkg::t_ctl               i_ctl,
    input  logic [SCAN_W-1:0]           i_scan_idx,
    output logic [IW-1:0]               o_i0,
    output logic [IW-1:0]               o_i1,
    output logic [15:0]                 o_frac
);
    import tgi_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);

    logic [31:0]        ram_rdata;
    logic signed [31:0] d;
    logic               ram_we;
    logic [NW-1:0]      used;

    logic               r_vld_d;
    logic [SCAN_W-1:0]  r_idx_d;
    logic [NW-1:0]      r_n;
    logic signed [31:0] r_c;
    logic signed [31:0] r_p0, r_lo_v, r_hi_v;
    logic [IW-1:0]      r_p0_i, r_lo_i, r_hi_i, r_i0, r_i1;
    logic               r_lo_hit, r_hi_hit;
    logic               r_zero, r_sat;
    logic [33:0]        r_rem;
    logic [32:0]        r_ud;
    logic [15:0]        r_q;

    logic signed [31:0] p0, v0;
    logic [IW-1:0]      idx, i0;
    logic               in_use, is_last, single;
    logic signed [32:0] num, den;
    logic [32:0]        un, ud;
    logic [33:0]        rem2;
    logic               ge;

    assign ram_we = i_we && (32'(i_waddr) < MAX_POINTS);

    tgi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_waddr[IW-1:0]),
        .i_wdata (i_wdata),
        .i_raddr (i_scan_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (i_points == '0) begin
            used = NW'(1);
        end else if (32'(i_points) > MAX_POINTS) begin
            used = NW'(MAX_POINTS);
        end else begin
            used = NW'(i_points);
        end
        d       = $signed(ram_rdata);
        idx     = r_idx_d[IW-1:0];
        in_use  = r_vld_d && (32'(r_idx_d) < 32'(r_n));
        is_last = (32'(r_idx_d) == 32'(r_n) - 32'd1);
        p0      = (r_idx_d == '0) ? d : r_p0;
        single  = (32'(r_n) < 32'd2);
        v0      = r_lo_hit ? r_lo_v : r_p0;
        i0      = r_lo_hit ? r_lo_i : r_p0_i;
        num     = 33'(r_c) - 33'(v0);
        den     = 33'(r_hi_v) - 33'(v0);
        un      = num[32] ? 33'(-num) : 33'(num);
        ud      = den[32] ? 33'(-den) : 33'(den);
        rem2    = {r_rem[32:0], 1'b0};
        ge      = rem2 >= {1'b0, r_ud};
    end

    always_ff @(posedge i_clk) begin
        r_vld_d <= i_ctl.scan_vld;
        r_idx_d <= i_scan_idx;
        if (i_ctl.start) begin
            r_c      <= i_coord;
            r_n      <= used;
            r_lo_hit <= 1'b0;
            r_hi_hit <= 1'b0;
        end
        if (in_use) begin
            if (r_idx_d == '0) begin
                r_p0 <= d;
            end
            if (d == p0) begin
                r_p0_i <= idx;
            end
            if (d <= r_c) begin
                r_lo_hit <= 1'b1;
                r_lo_v   <= d;
                r_lo_i   <= idx;
            end
            if (!r_hi_hit) begin
                if (d >= r_c || is_last) begin
                    r_hi_hit <= 1'b1;
                    r_hi_v   <= d;
                    r_hi_i   <= idx;
                end
            end else if (d == r_hi_v) begin
                r_hi_i <= idx;
            end
        end
        if (i_ctl.div_init) begin
            r_i0   <= single ? '0 : i0;
            r_i1   <= single ? '0 : r_hi_i;
            r_zero <= single || (v0 == r_hi_v) || (num == '0) || (num[32] != den[32]);
            r_sat  <= un >= ud;
            r_rem  <= 34'(un);
            r_ud   <= ud;
            r_q    <= '0;
        end else if (i_ctl.div_step) begin
            r_rem <= ge ? rem2 - {1'b0, r_ud} : rem2;
            r_q   <= {r_q[14:0], ge};
        end
    end

    assign o_i0   = r_i0;
    assign o_i1   = r_i1;
    assign o_frac = r_zero ? 16'd0 : (r_sat ? 16'hFFFF : r_q);
endmodule

// ----- rtl/tgi_blend.sv -----
// Grid store, corner fetch and serial trilinear blend.
module tgi_blend #(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16,
    parameter int MAX_Z_POINTS = 16,
    localparam int XW = $clog2(MAX_X_POINTS),
    localparam int YW = $clog2(MAX_Y_POINTS),
    localparam int ZW = $clog2(MAX_Z_POINTS)
) (
    input  logic               i_clk,
    input  tgi_pkg::t_ctl      i_ctl,
    input  logic               i_we,
    input  logic [11:0]        i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic [XW-1:0]      i_x0,
    input  logic [XW-1:0]      i_x1,
    input  logic [YW-1:0]      i_y0,
    input  logic [YW-1:0]      i_y1,
    input  logic [ZW-1:0]      i_z0,
    input  logic [ZW-1:0]      i_z1,
    input  logic [15:0]        i_fx,
    input  logic [15:0]        i_fy,
    input  logic [15:0]        i_fz,
    output logic [31:0]        o_result
);
    import tgi_pkg::*;

    localparam int DEPTH = MAX_X_POINTS * MAX_Y_POINTS * MAX_Z_POINTS;
    localparam int GW = $clog2(DEPTH);

    logic [31:0]        rdata;
    logic               ram_we;
    logic [GW-1:0]      raddr;
    logic [XW-1:0]      xs;
    logic [YW-1:0]      ys;
    logic [ZW-1:0]      zs;

    logic signed [31:0] r_val [CORNERS];
    logic               r_rd_vld_d;
    logic [2:0]         r_rd_k_d;
    logic signed [31:0] r_a;
    logic signed [49:0] r_prod;
    logic [31:0]        r_out;

    logic [1:0]         pair;
    logic [15:0]        f;
    logic signed [32:0] diff;
    logic signed [50:0] sum;
    logic signed [34:0] res;
    logic signed [31:0] sat;

    assign ram_we = i_we && (32'(i_waddr) < DEPTH);

    always_comb begin
        xs    = i_ctl.rd_k[0] ? i_x1 : i_x0;
        ys    = i_ctl.rd_k[1] ? i_y1 : i_y0;
        zs    = i_ctl.rd_k[2] ? i_z1 : i_z0;
        raddr = GW'((32'(xs) * MAX_Y_POINTS + 32'(ys)) * MAX_Z_POINTS + 32'(zs));
    end

    tgi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (GW'(i_waddr)),
        .i_wdata (i_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        if (i_ctl.bl_step < 3'd4) begin
            pair = i_ctl.bl_step[1:0];
            f    = i_fx;
        end else if (i_ctl.bl_step < 3'd6) begin
            pair = 2'(i_ctl.bl_step - 3'd4);
            f    = i_fy;
        end else begin
            pair = 2'd0;
            f    = i_fz;
        end
        diff = 33'(r_val[{pair, 1'b1}]) - 33'(r_val[{pair, 1'b0}]);
        sum  = (51'(r_a) <<< 16) + 51'(r_prod) + 51'(32768);
        res  = sum[50:16];
        if (res > 35'sd2147483647) begin
            sat = 32'sh7FFFFFFF;
        end else if (res < -35'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld_d <= i_ctl.rd_vld;
        r_rd_k_d   <= i_ctl.rd_k;
        if (r_rd_vld_d) begin
            r_val[r_rd_k_d] <= $signed(rdata);
        end
        if (i_ctl.bl_vld && !i_ctl.bl_phase) begin
            r_a    <= r_val[{pair, 1'b0}];
            r_prod <= diff * $signed({1'b0, f});
        end
        if (i_ctl.bl_vld && i_ctl.bl_phase) begin
            r_val[{1'b0, pair}] <= sat;
        end
        if (i_ctl.out_load) begin
            r_out <= r_val[0];
        end
    end

    assign o_result = r_out;
endmodule

// ----- rtl/tgi_ctrl.sv -----
// Query sequencer: scan, divide, corner fetch, blend, output.
module tgi_ctrl #(
    parameter int SCAN_MAX = 16,
    localparam int SW = $clog2(SCAN_MAX)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_query,
    input  logic          i_out_busy,
    output logic          o_idle,
    output logic [SW-1:0] o_scan_idx,
    output tgi_pkg::t_ctl o_ctl
);
    import tgi_pkg::*;

    localparam int TOP = (SCAN_MAX + 1 > DIV_STEPS + 1) ? SCAN_MAX + 1 : DIV_STEPS + 1;
    localparam int CW  = $clog2(TOP + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CW'(1);
        o_ctl   = '0;
        o_ctl.rd_k     = r_cnt[2:0];
        o_ctl.bl_phase = r_cnt[0];
        o_ctl.bl_step  = r_cnt[3:1];
        o_idle  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                n_cnt  = '0;
                if (i_query) begin
                    o_ctl.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_ctl.scan_vld = (r_cnt < CW'(SCAN_MAX));
                if (r_cnt == CW'(SCAN_MAX)) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                o_ctl.div_init = (r_cnt == '0);
                o_ctl.div_step = (r_cnt != '0);
                if (r_cnt == CW'(DIV_STEPS)) begin
                    n_state = ST_READ;
                    n_cnt   = '0;
                end
            end
            ST_READ: begin
                o_ctl.rd_vld = (r_cnt < CW'(CORNERS));
                if (r_cnt == CW'(CORNERS)) begin
                    n_state = ST_BLEND;
                    n_cnt   = '0;
                end
            end
            ST_BLEND: begin
                o_ctl.bl_vld = 1'b1;
                if (r_cnt == CW'(BLEND_CYCLES - 1)) begin
                    n_state = ST_OUT;
                    n_cnt   = '0;
                end
            end
            ST_OUT: begin
                n_cnt = '0;
                if (!i_out_busy) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_scan_idx = r_cnt[SW-1:0];
endmodule

// ----- rtl/trilinear_grid_interpolator_unit.sv -----
// A query runs a point scan over max(MAX_*_POINTS) points, a 16-step divider,
// 8 grid RAM reads and 7 blends (a multiply phase, then a write-back phase) on one
// multiplier. One query is in flight at a time; the next item is taken in the cycle
// after the result is loaded.
// A finished result may wait in the output register while the next item is taken.
// Reset (i_rst_n low, synchronous) idles the sequencer, drops m_axis_tvalid and
// sets the point counts to 1; tables and grid hold whatever was last written.
module trilinear_grid_interpolator_unit #(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16,
    parameter int MAX_Z_POINTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // command, location, load_value, coord_x, coord_y, coord_z, zero pad
    input  logic [tgi_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // blended_value
    output logic [tgi_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [tgi_pkg::CNT_REG_W-1:0]     i_cfg_data
);
    import tgi_pkg::*;

    localparam int SMXY = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int SCAN_MAX = (SMXY > MAX_Z_POINTS) ? SMXY : MAX_Z_POINTS;
    localparam int SW = $clog2(SCAN_MAX);
    localparam int XW = $clog2(MAX_X_POINTS);
    localparam int YW = $clog2(MAX_Y_POINTS);
    localparam int ZW = $clog2(MAX_Z_POINTS);

    logic [2:0]          in_cmd;
    logic [11:0]         in_loc;
    logic signed [31:0]  in_val, in_cx, in_cy, in_cz;
    logic                acc, idle, out_busy;
    t_ctl                ctl;
    logic [SW-1:0]       scan_idx;
    logic [XW-1:0]       x0, x1;
    logic [YW-1:0]       y0, y1;
    logic [ZW-1:0]       z0, z1;
    logic [15:0]         fx, fy, fz;
    logic [31:0]         result;

    logic [CNT_REG_W-1:0] r_x_points, r_y_points, r_z_points;
    logic                 r_m_valid;

    assign in_cmd = s_axis_tdata[2:0];
    assign in_loc = s_axis_tdata[14:3];
    assign in_val = s_axis_tdata[46:15];
    assign in_cx  = s_axis_tdata[78:47];
    assign in_cy  = s_axis_tdata[110:79];
    assign in_cz  = s_axis_tdata[142:111];

    assign s_axis_tready = idle;
    assign acc           = s_axis_tvalid && idle;
    assign out_busy      = r_m_valid && !m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_points <= CNT_REG_W'(1);
            r_y_points <= CNT_REG_W'(1);
            r_z_points <= CNT_REG_W'(1);
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_X_POINTS: r_x_points <= i_cfg_data;
                    REG_Y_POINTS: r_y_points <= i_cfg_data;
                    REG_Z_POINTS: r_z_points <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ctl.out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    tgi_ctrl #(.SCAN_MAX(SCAN_MAX)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_query    (acc && in_cmd == CMD_QUERY),
        .i_out_busy (out_busy),
        .o_idle     (idle),
        .o_scan_idx (scan_idx),
        .o_ctl      (ctl)
    );

    tgi_axis #(.MAX_POINTS(MAX_X_POINTS), .SCAN_W(SW)) u_ax_x (
        .i_clk      (i_clk),
        .i_we       (acc && in_cmd == CMD_LOAD_X),
        .i_waddr    (in_loc),
        .i_wdata    (in_val),
        .i_points   (r_x_points),
        .i_coord    (in_cx),
        .i_ctl      (ctl),
        .i_scan_idx (scan_idx),
        .o_i0       (x0),
        .o_i1       (x1),
        .o_frac     (fx)
    );

    tgi_axis #(.MAX_POINTS(MAX_Y_POINTS), .SCAN_W(SW)) u_ax_y (
        .i_clk      (i_clk),
        .i_we       (acc && in_cmd == CMD_LOAD_Y),
        .i_waddr    (in_loc),
        .i_wdata    (in_val),
        .i_points   (r_y_points),
        .i_coord    (in_cy),
        .i_ctl      (ctl),
        .i_scan_idx (scan_idx),
        .o_i0       (y0),
        .o_i1       (y1),
        .o_frac     (fy)
    );

    tgi_axis #(.MAX_POINTS(MAX_Z_POINTS), .SCAN_W(SW)) u_ax_z (
        .i_clk      (i_clk),
        .i_we       (acc && in_cmd == CMD_LOAD_Z),
        .i_waddr    (in_loc),
        .i_wdata    (in_val),
        .i_points   (r_z_points),
        .i_coord    (in_cz),
        .i_ctl      (ctl),
        .i_scan_idx (scan_idx),
        .o_i0       (z0),
        .o_i1       (z1),
        .o_frac     (fz)
    );

    tgi_blend #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS),
        .MAX_Z_POINTS (MAX_Z_POINTS)
    ) u_blend (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_we     (acc && in_cmd == CMD_LOAD_G),
        .i_waddr  (in_loc),
        .i_wdata  (in_val),
        .i_x0     (x0),
        .i_x1     (x1),
        .i_y0     (y0),
        .i_y1     (y1),
        .i_z0     (z0),
        .i_z1     (z1),
        .i_fx     (fx),
        .i_fy     (fy),
        .i_fz     (fz),
        .o_result (result)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = result;
endmodule

// ----- test/tb_trilinear_grid_interpolator_unit.sv -----
// Testbench for the trilinear grid interpolator: loads, queries and register settings.
`timescale 1ns / 1ps

module tb_trilinear_grid_interpolator_unit;
    import tgi_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // command, location, load_value, coord_x, coord_y, coord_z, zero pad
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // blended_value
    logic [OUT_W-1:0] m_axis_tdata;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CNT_REG_W-1:0] i_cfg_data;

    trilinear_grid_interpolator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic signed [31:0] xs[16], ys[16], zs[16];
    logic signed [31:0] grid[4096];
    bit x_wr[16], y_wr[16], z_wr[16], g_wr[4096];
    int unsigned nx_reg, ny_reg, nz_reg;

    logic [31:0] expected_values[$];
    int errors;
    int checked;
    int queries;
    int hold_cycles;
    bit rx_random;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("[trilinear_grid_interpolator_unit] ERROR");
        $finish;
    end

    function automatic int unsigned eff_count(int unsigned r);
        if (r < 1) return 1;
        if (r > 16) return 16;
        return r;
    endfunction

    function automatic int unsigned last_match(ref logic signed [31:0] p[16],
                                               input int unsigned n,
                                               input logic signed [31:0] v);
        int unsigned idx;
        idx = 0;
        for (int i = 0; i < n; i++) if (p[i] == v) idx = i;
        return idx;
    endfunction

    function automatic int unsigned axis_frac(ref logic signed [31:0] p[16],
                                              input int unsigned n,
                                              input logic signed [31:0] c,
                                              output int unsigned i0,
                                              output int unsigned i1);
        logic signed [31:0] lo, hi;
        bit found;
        longint num, den, q;
        lo = p[0];
        hi = p[n-1];
        found = 0;
        i0 = 0;
        i1 = 0;
        if (n < 2) return 0;
        for (int i = 0; i < n; i++) if (p[i] <= c) lo = p[i];
        for (int i = 0; i < n; i++)
            if (!found && p[i] >= c) begin
                hi = p[i];
                found = 1;
            end
        i0 = last_match(p, n, lo);
        i1 = last_match(p, n, hi);
        if (lo == hi) return 0;
        num = longint'(c) - longint'(lo);
        den = longint'(hi) - longint'(lo);
        if (num == 0) return 0;
        if ((num < 0) != (den < 0)) return 0;
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        q = (num <<< 16) / den;
        return q > 65535 ? 65535 : int'(q);
    endfunction

    function automatic longint mix(longint a, longint b, int unsigned f);
        longint s;
        s = a * longint'(65536 - f) + b * longint'(f) + 32768;
        return s >>> 16;
    endfunction

    function automatic logic [31:0] blend_query(logic signed [31:0] cx,
                                                logic signed [31:0] cy,
                                                logic signed [31:0] cz);
        int unsigned fx, fy, fz, x0, x1, y0, y1, z0, z1;
        longint c00, c01, c10, c11, c0, c1, r;
        fx = axis_frac(xs, eff_count(nx_reg), cx, x0, x1);
        fy = axis_frac(ys, eff_count(ny_reg), cy, y0, y1);
        fz = axis_frac(zs, eff_count(nz_reg), cz, z0, z1);
        c00 = mix(grid[x0*256+y0*16+z0], grid[x1*256+y0*16+z0], fx);
        c01 = mix(grid[x0*256+y0*16+z1], grid[x1*256+y0*16+z1], fx);
        c10 = mix(grid[x0*256+y1*16+z0], grid[x1*256+y1*16+z0], fx);
        c11 = mix(grid[x0*256+y1*16+z1], grid[x1*256+y1*16+z1], fx);
        c0 = mix(c00, c10, fy);
        c1 = mix(c01, c11, fy);
        r = mix(c0, c1, fz);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic send_item(logic [2:0] cmd, logic [11:0] loc, logic [31:0] val,
                             logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, cz, cy, cx, val, loc, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (cmd)
            CMD_LOAD_X: if (loc < 16) begin xs[loc] = val; x_wr[loc] = 1; end
            CMD_LOAD_Y: if (loc < 16) begin ys[loc] = val; y_wr[loc] = 1; end
            CMD_LOAD_Z: if (loc < 16) begin zs[loc] = val; z_wr[loc] = 1; end
            CMD_LOAD_G: begin grid[loc] = val; g_wr[loc] = 1; end
            CMD_QUERY: begin
                expected_values.push_back(blend_query(cx, cy, cz));
                queries++;
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (rx_random && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_values.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                logic [31:0] e;
                e = expected_values.pop_front();
                checked++;
                if (e !== m_axis_tdata) begin
                    errors++;
                    if (errors <= 10)
                        $display("blended_value mismatch: exp %h got %h", e, m_axis_tdata);
                end
            end
        end
    end

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_values.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_count(t_reg idx, int unsigned v);
        s_axis_tvalid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v[4:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_X_POINTS: nx_reg = v;
            REG_Y_POINTS: ny_reg = v;
            default: nz_reg = v;
        endcase
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    // sorted axis of n points, duplicates allowed, stored in the x/y/z shadow via loads
    task automatic load_axis(logic [2:0] cmd, int unsigned n);
        logic signed [31:0] v;
        v = $signed($urandom_range(0, 400000)) - 600000;
        if ($urandom_range(0, 7) == 0) v = 32'sh80000000;
        for (int i = 0; i < n; i++) begin
            send_item(cmd, i[11:0], v, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 4) != 0) begin
                if (v < 32'sh7fff0000) v = v + $urandom_range(1, 200000);
                if ($urandom_range(0, 9) == 0 && v < 0) v = 32'sh7fffffff;
            end
        end
    endtask

    task automatic load_grid(int unsigned nx, int unsigned ny, int unsigned nz);
        for (int x = 0; x < nx; x++)
            for (int y = 0; y < ny; y++)
                for (int z = 0; z < nz; z++)
                    send_item(CMD_LOAD_G, 12'(x*256+y*16+z), rnd_val(), 0, 0, 0);
    endtask

    function automatic logic [31:0] rnd_coord(ref logic signed [31:0] p[16],
                                              input int unsigned n);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return p[$urandom_range(0, n-1)];
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return p[0] + $urandom_range(0, 2000000) - 100000;
        endcase
    endfunction

    task automatic query_random();
        send_item(CMD_QUERY, 12'($urandom), $urandom,
                  rnd_coord(xs, eff_count(nx_reg)), rnd_coord(ys, eff_count(ny_reg)),
                  rnd_coord(zs, eff_count(nz_reg)));
    endtask

    task automatic setup_tables(int unsigned nx, int unsigned ny, int unsigned nz);
        write_count(REG_X_POINTS, nx);
        write_count(REG_Y_POINTS, ny);
        write_count(REG_Z_POINTS, nz);
        load_axis(CMD_LOAD_X, eff_count(nx));
        load_axis(CMD_LOAD_Y, eff_count(ny));
        load_axis(CMD_LOAD_Z, eff_count(nz));
        load_grid(eff_count(nx), eff_count(ny), eff_count(nz));
    endtask

    task automatic test_directed();
        // single point per axis, then extremes and out-of-range/unknown items
        setup_tables(1, 1, 1);
        send_item(CMD_QUERY, 0, 0, 32'h80000000, 32'h7fffffff, 0);
        send_item(CMD_LOAD_G, 12'hfff, 32'h7fffffff, 0, 0, 0);
        send_item(CMD_LOAD_X, 12'hfff, 32'h12345678, 0, 0, 0);
        send_item(CMD_LOAD_Y, 12'd16, 32'h12345678, 0, 0, 0);
        send_item(CMD_LOAD_Z, 12'd100, 32'h12345678, 0, 0, 0);
        send_item(3'd5, 12'hfff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(3'd6, 0, 0, 0, 0, 0);
        send_item(3'd7, 12'h555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
        drain();
        setup_tables(0, 2, 2);
        send_item(CMD_QUERY, 12'hfff, 32'hffffffff, 32'h80000000, 32'h80000000,
                  32'h80000000);
        send_item(CMD_QUERY, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_item(CMD_QUERY, 0, 0, 0, ys[0], zs[1]);
        drain();
    endtask

    task automatic test_random_sets();
        int unsigned nx, ny, nz;
        for (int s = 0; s < 14; s++) begin
            rx_random = (s % 3 != 0);
            case (s)
                0: begin nx = 16; ny = 16; nz = 16; end
                1: begin nx = 31; ny = 2; nz = 1; end
                2: begin nx = 2; ny = 2; nz = 2; end
                default: begin
                    nx = $urandom_range(0, 5);
                    ny = $urandom_range(0, 5);
                    nz = $urandom_range(0, 5);
                end
            endcase
            if (s == 0) begin
                write_count(REG_X_POINTS, nx);
                write_count(REG_Y_POINTS, ny);
                write_count(REG_Z_POINTS, nz);
                load_axis(CMD_LOAD_X, 16);
                load_axis(CMD_LOAD_Y, 16);
                load_axis(CMD_LOAD_Z, 16);
                // full grid is too costly; fill only the corners of the first cell
                for (int i = 0; i < 4096; i++)
                    if (!g_wr[i]) begin
                        grid[i] = 0;
                    end
                load_grid(2, 2, 2);
                write_count(REG_X_POINTS, 2);
                write_count(REG_Y_POINTS, 2);
                write_count(REG_Z_POINTS, 2);
            end else begin
                setup_tables(nx, ny, nz);
            end
            for (int q = 0; q < 40; q++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(3'($urandom_range(5, 7)), 12'($urandom), $urandom,
                              $urandom, $urandom, $urandom);
                else if ($urandom_range(0, 9) == 0)
                    send_item(CMD_LOAD_G, 12'($urandom_range(0, 1) * 256 + 17), rnd_val(),
                              0, 0, 0);
                else
                    query_random();
            end
            if (s == 4) begin
                hold_cycles = 600;
                for (int q = 0; q < 12; q++) query_random();
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        checked = 0;
        queries = 0;
        hold_cycles = 0;
        rx_random = 1;
        nx_reg = 1; ny_reg = 1; nz_reg = 1;
        for (int i = 0; i < 16; i++) begin xs[i] = 0; ys[i] = 0; zs[i] = 0; end
        for (int i = 0; i < 4096; i++) grid[i] = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_sets();
        drain();
        $display("covered loads, ignored items, %0d queries over point counts 0..31,", queries);
        $display("%0d results checked with random stalls and a long output hold", checked);
        if (errors == 0 && expected_values.size() == 0) begin
            $display("[trilinear_grid_interpolator_unit] OK");
        end else begin
            $display("[trilinear_grid_interpolator_unit] ERROR");
        end
        $finish;
    end
endmodule
